### rtl/sks_pkg.sv
// Shared types and constants of the stable key sorter.
`timescale 1ns / 1ps
`default_nettype none

package sks_pkg;

    // Store depth and field widths
    localparam int CAPACITY = 32;
    localparam int TAG_W    = 16;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TDATA_W  = ((TAG_W + KEY_W + 7) / 8) * 8;

    // One stored item held by a cell
    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } entry_t;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic load;     // write the input item into the selected cell
        logic sort;     // odd-even compare-exchange step
        logic shift;    // move every entry one cell towards cell 0
        logic desc;     // sort direction of this run
        logic phase;    // parity of the cells acting as lower partner
    } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/sks_cell.sv
// One cell of the sorting chain: holds an entry, exchanges with a neighbour.
`timescale 1ns / 1ps
`default_nettype none

module sks_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire sks_pkg::cell_ctrl_t ctrl,
    input  wire logic               load_sel,   // this cell is the next free slot
    input  wire logic               odd_pos,    // position parity in the chain
    input  wire sks_pkg::entry_t    in_item,
    input  wire sks_pkg::entry_t    below,      // neighbour towards cell 0
    input  wire sks_pkg::entry_t    above,      // neighbour away from cell 0
    output sks_pkg::entry_t         cur
);
    import sks_pkg::*;

    entry_t cur_reg;
    entry_t cur_next;
    entry_t lo;
    entry_t hi;
    entry_t sorted;
    logic   is_lower;
    logic   swap;

    // Compare-exchange with the partner chosen by the phase parity
    always_comb begin
        is_lower = (odd_pos == ctrl.phase);
        lo       = is_lower ? cur_reg : below;
        hi       = is_lower ? above   : cur_reg;
        // strict compare only, so equal keys never pass each other
        if (ctrl.desc) begin
            swap = lo.valid && hi.valid && ($signed(lo.key) < $signed(hi.key));
        end else begin
            swap = lo.valid && hi.valid && ($signed(lo.key) > $signed(hi.key));
        end
        if (swap) begin
            sorted = is_lower ? above : below;
        end else begin
            sorted = cur_reg;
        end
    end

    // Next entry
    always_comb begin
        cur_next = cur_reg;
        if (ctrl.load && load_sel) begin
            cur_next = in_item;
        end else if (ctrl.sort) begin
            cur_next = sorted;
        end else if (ctrl.shift) begin
            cur_next = above;
        end
    end

    // Valid bit is control, key and tag are payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg.valid <= 1'b0;
        end else begin
            cur_reg.valid <= cur_next.valid;
        end
        cur_reg.key <= cur_next.key;
        cur_reg.tag <= cur_next.tag;
    end

    assign cur = cur_reg;

endmodule

`default_nettype wire

### rtl/stable_key_sorter.sv
// Top level: stable sorter built as a chain of odd-even transposition cells.
//
//  channel   direction  handshake          payload
//  s_*       in         tvalid/tready      tdata = {sort_key, item_tag}, tlast = last_item
//  m_*       out        tvalid/tready      tdata = {out_key, out_tag}, tlast, tuser = overflowed
//  cfg_*     in         write enable only  cfg_wr_data = sort_descending
//
//  Loading writes one item per cycle straight into the next free cell; items beyond
//  CAPACITY are dropped and flagged on tuser. After the last item the chain runs an
//  odd-even exchange pass, then shifts the n stored items out through cell 0, one per
//  cycle while m_tready is high; the input is closed from the last item until the final
//  result has left the chain. Reset empties the chain at once and leaves the output idle.
//  An output stall freezes the chain; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module stable_key_sorter (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_wr_data,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [sks_pkg::TDATA_W-1:0]   s_tdata,   // item_tag[15:0], sort_key[47:16]
    input  wire logic                          s_tlast,   // last_item
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [sks_pkg::TDATA_W-1:0]        m_tdata,   // out_tag[15:0], out_key[47:16]
    output logic                               m_tlast,   // out_last
    output logic                               m_tuser    // overflowed
);
    import sks_pkg::*;

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_SORT  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]       state_reg,  state_next;
    logic [CNT_W-1:0] fill_reg,   fill_next;
    logic [CNT_W-1:0] step_reg,   step_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             drop_reg,   drop_next;
    logic             desc_reg,   desc_next;
    logic             sort_descending_reg;

    logic             m_valid_reg, m_valid_next;
    logic [TAG_W-1:0] out_tag_reg;
    logic [KEY_W-1:0] out_key_reg;
    logic             out_last_reg;
    logic             out_ovf_reg;

    logic             accept;
    logic             full;
    logic             pop;
    cell_ctrl_t       ctrl;
    entry_t           in_item;
    entry_t           chain [CAPACITY+2];   // [0] and [CAPACITY+1] are empty ends

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sort_descending_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            sort_descending_reg <= cfg_wr_data;
        end
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign accept   = s_tvalid && s_tready;
    assign full     = (fill_reg == CNT_W'(CAPACITY));
    assign pop      = (state_reg == ST_DRAIN) && (remain_reg != '0)
                      && (!m_valid_reg || m_tready);

    assign in_item.valid = 1'b1;
    assign in_item.tag   = s_tdata[TAG_W-1:0];
    assign in_item.key   = s_tdata[TAG_W+KEY_W-1:TAG_W];

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        step_next   = step_reg;
        remain_next = remain_reg;
        drop_next   = drop_reg;
        desc_next   = desc_reg;
        case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (full) begin
                        drop_next = 1'b1;
                    end else begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    if (s_tlast) begin
                        remain_next = full ? fill_reg : fill_reg + CNT_W'(1);
                        desc_next   = sort_descending_reg;
                        step_next   = '0;
                        state_next  = ST_SORT;
                    end
                end
            end
            ST_SORT: begin
                step_next = step_reg + CNT_W'(1);
                if (step_reg == CNT_W'(CAPACITY - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (pop) begin
                    remain_next = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1)) begin
                        fill_next  = '0;
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            fill_reg   <= '0;
            step_reg   <= '0;
            remain_reg <= '0;
            drop_reg   <= 1'b0;
            desc_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            step_reg   <= step_next;
            remain_reg <= remain_next;
            drop_reg   <= drop_next;
            desc_reg   <= desc_next;
        end
    end

    // Broadcast control
    assign ctrl.load  = accept && !full;
    assign ctrl.sort  = (state_reg == ST_SORT);
    assign ctrl.shift = pop;
    assign ctrl.desc  = desc_reg;
    assign ctrl.phase = step_reg[0];

    // Cell chain
    assign chain[0]          = '0;
    assign chain[CAPACITY+1] = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        sks_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .load_sel (fill_reg == CNT_W'(i)),
            .odd_pos  (1'(i % 2)),
            .in_item  (in_item),
            .below    (chain[i]),
            .above    (chain[i+2]),
            .cur      (chain[i+1])
        );
    end

    // Output register fed from cell 0
    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (pop) begin
            out_tag_reg  <= chain[1].tag;
            out_key_reg  <= chain[1].key;
            out_last_reg <= (remain_reg == CNT_W'(1));
            out_ovf_reg  <= drop_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'({out_key_reg, out_tag_reg});
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

endmodule

`default_nettype wire

### rtl/sks_checker.sv
// Port-level checks of the stable key sorter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sks_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    input  wire logic                        s_tready,
    input  wire logic                        s_tlast,
    input  wire logic                        m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic [sks_pkg::TDATA_W-1:0] m_tdata,
    input  wire logic                        m_tlast,
    input  wire logic                        m_tuser
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result changed while stalled");

    // The last item closes the input for the sort
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still open after last item");

    // An offered result carries known bits
    a_out_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !$isunknown({m_tdata, m_tlast, m_tuser}))
        else $error("unknown bits on offered result");

    // Reset leaves the output idle and the input open
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("bad state after reset");

endmodule

bind stable_key_sorter sks_checker u_sks_checker (.*);

`default_nettype wire

### bench/stable_key_sorter_test.sv
// Self-checking testbench for the stable key sorter: stream driver, result monitor, sort predictor.
`timescale 1ns / 1ps

module stable_key_sorter_test;

    import sks_pkg::*;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic                    ORDER_ASC  = 1'b0;
    localparam logic                    ORDER_DESC = 1'b1;
    // exchange pass plus unload of a full chain, with margin
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;

    // one list entry as offered on the input stream
    typedef struct packed {
        logic [TAG_W-1:0]        tag;
        logic signed [KEY_W-1:0] key;
        logic                    last;
    } list_item_t;

    // one position of a sorted run
    typedef struct packed {
        logic [TAG_W-1:0]        tag;
        logic signed [KEY_W-1:0] key;
        logic                    last;
        logic                    ovf;
    } sorted_entry_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic               cfg_wr_data = 1'b0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata     = '0;
    logic               s_tlast     = 1'b0;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic               m_tuser;

    // pending input items and expected sorted output
    list_item_t    item_queue[$];
    sorted_entry_t sorted_due[$];
    int            n_queued   = 0;
    int            n_taken    = 0;
    int            fail_count = 0;
    int            send_idle  = 0;
    int            recv_idle  = 0;

    // shadow of the sorter's store and direction register
    logic signed [KEY_W-1:0] held_keys [CAPACITY];
    logic [TAG_W-1:0]        held_tags [CAPACITY];
    int                      held_count   = 0;
    logic                    held_dropped = 1'b0;
    logic                    desc_mode    = ORDER_ASC;

    stable_key_sorter u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    always #10 aclk = ~aclk;

    // Store an accepted item; on the last one, stable-sort the store into expectations
    function automatic void absorb_item(list_item_t it);
        int            order [CAPACITY];
        int            i;
        int            j;
        int            cur;
        int            prev;
        logic          move_up;
        sorted_entry_t ent;
        if (held_count < CAPACITY) begin
            held_keys[held_count] = it.key;
            held_tags[held_count] = it.tag;
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (!it.last)
            return;
        for (i = 0; i < held_count; i++) begin
            cur = i;
            j   = i;
            while (j > 0) begin
                prev    = order[j-1];
                move_up = (desc_mode == ORDER_DESC) ? (held_keys[cur] > held_keys[prev])
                                                    : (held_keys[prev] > held_keys[cur]);
                if (!move_up)
                    break;
                order[j] = prev;
                j--;
            end
            order[j] = cur;
        end
        for (i = 0; i < held_count; i++) begin
            ent.tag  = held_tags[order[i]];
            ent.key  = held_keys[order[i]];
            ent.last = (i == held_count - 1);
            ent.ovf  = held_dropped;
            sorted_due.push_back(ent);
        end
        held_count   = 0;
        held_dropped = 1'b0;
    endfunction

    // Driver: offer the next pending item, with random gaps
    always @(posedge aclk) begin
        list_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (item_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
                nxt      = item_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {nxt.key, nxt.tag};
                s_tlast  <= nxt.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: predict on input transfers, check every output transfer
    always @(posedge aclk) begin
        list_item_t    got_in;
        sorted_entry_t want;
        sorted_entry_t seen;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
            if (s_tvalid && s_tready) begin
                got_in.tag  = s_tdata[TAG_W-1:0];
                got_in.key  = s_tdata[TAG_W+KEY_W-1:TAG_W];
                got_in.last = s_tlast;
                absorb_item(got_in);
                n_taken++;
            end
            if (m_tvalid && m_tready) begin
                seen.tag  = m_tdata[TAG_W-1:0];
                seen.key  = m_tdata[TAG_W+KEY_W-1:TAG_W];
                seen.last = m_tlast;
                seen.ovf  = m_tuser;
                if (sorted_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: tag %h key %h last %b ovf %b",
                                 seen.tag, seen.key, seen.last, seen.ovf);
                end else begin
                    want = sorted_due.pop_front();
                    if (seen.tag !== want.tag || seen.key !== want.key ||
                        seen.last !== want.last || seen.ovf !== want.ovf) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: want tag %h key %h last %b ovf %b, ",
                                      "got tag %h key %h last %b ovf %b"},
                                     want.tag, want.key, want.last, want.ovf,
                                     seen.tag, seen.key, seen.last, seen.ovf);
                    end
                end
            end
        end
    end

    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(9))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2, 3:    return (int'($urandom_range(4)) - 2) * 65536;  // few values, many ties
            default: return $urandom;
        endcase
    endfunction

    task automatic add_item(logic [TAG_W-1:0] tag, logic signed [KEY_W-1:0] key, logic last);
        list_item_t it;
        it.tag  = tag;
        it.key  = key;
        it.last = last;
        item_queue.push_back(it);
        n_queued++;
    endtask

    task automatic add_random_list(int len);
        for (int i = 0; i < len; i++)
            add_item(TAG_W'($urandom_range(65535)), pick_key(), i == len - 1);
    endtask

    // Random lists: mostly short ones, now and then one near or beyond the store depth
    task automatic add_random_lists(int quota, bit with_overrun);
        int added;
        int len;
        added = 0;
        if (with_overrun) begin
            len = CAPACITY + 1 + $urandom_range(7);
            add_random_list(len);
            added += len;
        end
        while (added < quota) begin
            len = ($urandom_range(5) == 0) ? $urandom_range(CAPACITY + 8, CAPACITY - 2)
                                           : $urandom_range(10, 1);
            add_random_list(len);
            added += len;
        end
    endtask

    // Hold further input until every pending result is out and the chain has settled
    task automatic drain();
        while (item_queue.size() != 0 || n_taken != n_queued || sorted_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_order(logic dir);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= dir;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        desc_mode   = dir;
    endtask

    task automatic add_mixed_list();
        add_item(16'h0000, 32'sd0,     1'b0);
        add_item(16'hFFFF, -32'sd1,    1'b0);
        add_item(16'h5A5A, KEY_MIN,    1'b0);
        add_item(16'hA5A5, KEY_MAX,    1'b0);
        add_item(16'h0001, 32'sd1,     1'b0);
        add_item(16'h0002, KEY_MIN,    1'b0);  // tie with an earlier key
        add_item(16'h0003, 32'sd0,     1'b0);  // tie with the first item
        add_item(16'h8000, -32'sd65536, 1'b0);
        add_item(16'h7FFF, 32'sd65536, 1'b0);
        add_item(16'h1234, KEY_MAX,    1'b1);  // tie at the top end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle = 24;
        recv_idle = 69;

        // directed: single-item lists and extremes with ties, both directions
        set_order(ORDER_ASC);
        add_item(16'hFFFF, KEY_MAX, 1'b1);
        add_mixed_list();
        drain();
        set_order(ORDER_DESC);
        add_item(16'h0000, KEY_MIN, 1'b1);
        add_mixed_list();
        drain();

        // random lists under three idling patterns
        add_random_lists(25, 1'b1);
        drain();
        send_idle = 69;
        recv_idle = 24;
        set_order(ORDER_ASC);
        add_random_lists(25, 1'b0);
        drain();
        send_idle = 0;
        recv_idle = 0;
        set_order(ORDER_DESC);
        add_random_lists(20, 1'b0);
        drain();

        if (fail_count == 0) begin
            $display("stable_key_sorter_test: clean");
        end else begin
            $display("stable_key_sorter_test: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("stable_key_sorter_test: errors");
        $finish;
    end

endmodule
